### rtl/packed_iq_sample_unpacker_assert.svh
// Assertion macros for the packed I/Q sample unpacker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PACKED_IQ_SAMPLE_UNPACKER_ASSERT_SVH
`define PACKED_IQ_SAMPLE_UNPACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PIQSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PIQSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/piqsu_pkg.sv
// Shared widths and constants for the packed I/Q sample unpacker.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package piqsu_pkg;

  // Field widths of the input byte and of one decoded sample.
  localparam int BYTE_W    = 8;
  localparam int SAMPLE_W  = 10;
  localparam int CHAN_W    = 2;
  localparam int INDEX_W   = 16;
  localparam int CFG_W     = 16;

  // Only the low COUNT_BITS bits of the quad count register are used.
  localparam int COUNT_BITS = 16;
  localparam logic [CFG_W-1:0] COUNT_MASK = CFG_W'((1 << COUNT_BITS) - 1);

  // Block position counter width.
  localparam int POS_W = 17;

  // Byte position within a five-byte group of four samples.
  localparam logic [2:0] PHASE_HEAD = 3'd0;
  localparam logic [2:0] PHASE_S0   = 3'd1;
  localparam logic [2:0] PHASE_S1   = 3'd2;
  localparam logic [2:0] PHASE_S2   = 3'd3;
  localparam logic [2:0] PHASE_S3   = 3'd4;

  // Channel codes.
  localparam logic [CHAN_W-1:0] CHAN_I_EVEN = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_I_ODD  = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_Q_EVEN = 2'd2;
  localparam logic [CHAN_W-1:0] CHAN_Q_ODD  = 2'd3;

  // Quad count value after reset.
  localparam logic [CFG_W-1:0] NUM_QUADS_RESET = 16'd1;

endpackage

`default_nettype wire

### rtl/piqsu_byte_if.sv
// Valid/ready channel carrying one raw payload byte per transfer.
// Depends on piqsu_pkg for the byte width.
`default_nettype none

interface piqsu_byte_if;
  logic                              valid;
  logic                              ready;
  logic [piqsu_pkg::BYTE_W-1:0]      payload_byte;

  modport source (output valid, output payload_byte, input ready);
  modport sink   (input valid, input payload_byte, output ready);
endinterface

`default_nettype wire

### rtl/piqsu_sample_if.sv
// Valid/ready channel carrying one decoded sample per transfer.
// Depends on piqsu_pkg for the field widths.
`default_nettype none

interface piqsu_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [piqsu_pkg::SAMPLE_W-1:0] sample_value;
  logic        [piqsu_pkg::CHAN_W-1:0]   channel;
  logic        [piqsu_pkg::INDEX_W-1:0]  sample_index;
  logic                                  last_in_packet;

  modport source (output valid, output sample_value, output channel,
                  output sample_index, output last_in_packet, input ready);
  modport sink   (input valid, input sample_value, input channel,
                  input sample_index, input last_in_packet, output ready);
endinterface

`default_nettype wire

### rtl/packed_iq_sample_unpacker.sv
// Packed I/Q sample unpacker: ten-bit sign-magnitude samples from a byte stream.
// A sample is registered and appears on the output in the cycle after the byte that completes it.
// Throughput: one byte per cycle unless a held sample is stalled, set by the single
// output register, which is refilled in the same cycle that its sample transfers.
// Reset (rst, synchronous, active high) clears the position counters and the
// output valid, and sets the quad count to one. Uses piqsu_pkg and both interfaces.
`default_nettype none

`include "packed_iq_sample_unpacker_assert.svh"

module packed_iq_sample_unpacker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write_en,
  input  wire logic [piqsu_pkg::CFG_W-1:0]       cfg_write_data,
  piqsu_byte_if.sink                             byte_in,
  piqsu_sample_if.source                         sample_out
);

  // Configuration and packet position state.
  logic [piqsu_pkg::CFG_W-1:0]    num_quads;
  logic [piqsu_pkg::POS_W-1:0]    byte_in_block;
  logic [piqsu_pkg::INDEX_W-1:0]  samples_done;
  logic [piqsu_pkg::CHAN_W-1:0]   current_channel;
  logic [2:0]                     group_phase;
  logic [piqsu_pkg::BYTE_W-1:0]   held_byte;

  // Output register.
  logic                                  out_valid;
  logic signed [piqsu_pkg::SAMPLE_W-1:0] out_value;
  logic        [piqsu_pkg::CHAN_W-1:0]   out_channel;
  logic        [piqsu_pkg::INDEX_W-1:0]  out_index;
  logic                                  out_last;

  // Decode signals.
  logic                              in_ready;
  logic                              byte_xfer;
  logic [piqsu_pkg::CFG_W-1:0]       quad_count;
  logic [19:0]                       ten_n;
  logic [piqsu_pkg::POS_W-1:0]       block_last;
  logic                              block_end;
  logic [piqsu_pkg::SAMPLE_W-1:0]    raw;
  logic                              have_sample;
  logic                              emit;
  logic [8:0]                        magnitude;
  logic [piqsu_pkg::SAMPLE_W-1:0]    twos_value;
  logic                              is_last;
  logic [2:0]                        group_phase_next;

  // The output register takes a new sample when it is empty or being emptied.
  assign in_ready  = !out_valid || sample_out.ready;
  assign byte_xfer = byte_in.valid && in_ready;

  // Block length minus one is 2*floor(10*n/16)+1.
  assign quad_count = num_quads & piqsu_pkg::COUNT_MASK;
  assign ten_n      = ({4'd0, quad_count} << 3) + ({4'd0, quad_count} << 1);
  assign block_last = {ten_n[19:4], 1'b1};
  assign block_end  = byte_in_block >= block_last;

  // Assemble the ten bits that end in this byte.
  always_comb begin
    raw         = '0;
    have_sample = 1'b0;
    unique case (group_phase)
      piqsu_pkg::PHASE_S0: begin
        raw         = {held_byte, byte_in.payload_byte[7:6]};
        have_sample = 1'b1;
      end
      piqsu_pkg::PHASE_S1: begin
        raw         = {held_byte[5:0], byte_in.payload_byte[7:4]};
        have_sample = 1'b1;
      end
      piqsu_pkg::PHASE_S2: begin
        raw         = {held_byte[3:0], byte_in.payload_byte[7:2]};
        have_sample = 1'b1;
      end
      piqsu_pkg::PHASE_S3: begin
        raw         = {held_byte[1:0], byte_in.payload_byte};
        have_sample = 1'b1;
      end
      default: begin
        raw         = '0;
        have_sample = 1'b0;
      end
    endcase
  end

  // Sign-magnitude to two's complement; negative zero becomes zero.
  assign magnitude  = raw[8:0];
  assign twos_value = raw[9] ? (10'd0 - {1'b0, magnitude}) : {1'b0, magnitude};

  assign emit    = byte_xfer && have_sample && (samples_done < quad_count);
  assign is_last = (current_channel == piqsu_pkg::CHAN_Q_ODD) &&
                   (({1'b0, samples_done} + 17'd1) == {1'b0, quad_count});

  assign group_phase_next = (group_phase >= piqsu_pkg::PHASE_S3) ?
                            piqsu_pkg::PHASE_HEAD : group_phase + 3'd1;

  // Quad count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_quads <= piqsu_pkg::NUM_QUADS_RESET;
    end else if (cfg_write_en) begin
      num_quads <= cfg_write_data;
    end
  end

  // Packet position tracking, advanced on every byte transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_block   <= '0;
      samples_done    <= '0;
      current_channel <= piqsu_pkg::CHAN_I_EVEN;
      group_phase     <= piqsu_pkg::PHASE_HEAD;
      held_byte       <= '0;
    end else if (byte_xfer) begin
      held_byte <= byte_in.payload_byte;
      if (block_end) begin
        byte_in_block   <= '0;
        samples_done    <= '0;
        group_phase     <= piqsu_pkg::PHASE_HEAD;
        current_channel <= current_channel + 2'd1;
      end else begin
        byte_in_block <= byte_in_block + 17'd1;
        group_phase   <= group_phase_next;
        if (emit) begin
          samples_done <= samples_done + 16'd1;
        end
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= emit;
    end
  end

  // Output payload, loaded when a sample is completed.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_value   <= twos_value;
      out_channel <= current_channel;
      out_index   <= samples_done;
      out_last    <= is_last;
    end
  end

  assign byte_in.ready            = in_ready;
  assign sample_out.valid         = out_valid;
  assign sample_out.sample_value  = out_value;
  assign sample_out.channel       = out_channel;
  assign sample_out.sample_index  = out_index;
  assign sample_out.last_in_packet = out_last;

  // A held sample must stall the byte input.
  `PIQSU_ASSERT_NOW(a_stall_blocks_input, out_valid && !sample_out.ready, !byte_in.ready,
    "byte input ready while a sample is stalled")

  // The end of a block restarts the sample count and group phase.
  `PIQSU_ASSERT_NEXT(a_block_restart, byte_xfer && block_end,
    samples_done == '0 && group_phase == piqsu_pkg::PHASE_HEAD && byte_in_block == '0,
    "block end did not restart the position counters")

  // Only the fourth channel can carry the packet end flag.
  `PIQSU_ASSERT_NOW(a_last_on_q_odd, out_valid && out_last,
    out_channel == piqsu_pkg::CHAN_Q_ODD, "last_in_packet on a channel other than Q-odd")

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for the packed I/Q sample unpacker: byte stimulus, a cycle-free decoder model
// and an in-order sample scoreboard. Depends on piqsu_pkg, piqsu_byte_if and piqsu_sample_if.

module testbench;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_MAX   = 10;

  // One decoded sample as it leaves the block.
  typedef struct packed {
    logic signed [piqsu_pkg::SAMPLE_W-1:0] sample_value;
    logic        [piqsu_pkg::CHAN_W-1:0]   channel;
    logic        [piqsu_pkg::INDEX_W-1:0]  sample_index;
    logic                                  last_in_packet;
  } sample_t;

  // Directed rows: a register write, a byte that must stay silent, a byte with a
  // hand-written sample, or a byte checked against the decoder model.
  typedef enum logic [1:0] {ROW_CFG, ROW_QUIET, ROW_TYPED, ROW_CHECKED} row_kind_t;

  typedef struct {
    row_kind_t                        kind;
    logic [piqsu_pkg::BYTE_W-1:0]     value;
    logic [piqsu_pkg::CFG_W-1:0]      quads_val;
    sample_t                          want;
  } stim_row_t;

  typedef struct {
    logic [piqsu_pkg::CFG_W-1:0] quads_val;
    int                          idle;
    int                          stall;
    int                          count;
    int                          hold_at;
    int                          drain_at;
  } phase_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_write_en;
  logic [piqsu_pkg::CFG_W-1:0]    cfg_write_data;

  piqsu_byte_if   byte_ch ();
  piqsu_sample_if sample_ch ();

  packed_iq_sample_unpacker dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .byte_in        (byte_ch),
    .sample_out     (sample_ch)
  );

  // Decoder model state.
  logic [piqsu_pkg::CFG_W-1:0]   quads;
  logic [piqsu_pkg::POS_W-1:0]   blk_pos;
  logic [piqsu_pkg::INDEX_W-1:0] blk_samples;
  logic [piqsu_pkg::CHAN_W-1:0]  rx_chan;
  logic [2:0]                    grp_phase;
  logic [piqsu_pkg::BYTE_W-1:0]  prev_byte;

  sample_t   expected_samples[$];
  stim_row_t rows[$];
  phase_t    plan[8];

  int cycles = 0;
  int failures = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  sample_t got_sample;
  sample_t want_sample;

  // Clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Watchdog on the whole run.
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void decoder_reset();
    quads       = piqsu_pkg::NUM_QUADS_RESET;
    blk_pos     = '0;
    blk_samples = '0;
    rx_chan     = piqsu_pkg::CHAN_I_EVEN;
    grp_phase   = piqsu_pkg::PHASE_HEAD;
    prev_byte   = '0;
  endfunction

  // Consumes one payload byte and yields the sample that it completes, if any.
  function automatic void decode_step(input logic [piqsu_pkg::BYTE_W-1:0] b,
                                      output bit have, output sample_t res);
    logic [piqsu_pkg::SAMPLE_W-1:0] raw;
    logic [8:0]                     mag;
    bit                             full;
    int                             n;
    int                             len;
    n    = int'(quads & piqsu_pkg::COUNT_MASK);
    full = 1'b1;
    raw  = '0;
    res  = '0;
    case (grp_phase)
      piqsu_pkg::PHASE_S0: raw = {prev_byte, b[7:6]};
      piqsu_pkg::PHASE_S1: raw = {prev_byte[5:0], b[7:4]};
      piqsu_pkg::PHASE_S2: raw = {prev_byte[3:0], b[7:2]};
      piqsu_pkg::PHASE_S3: raw = {prev_byte[1:0], b};
      default: full = 1'b0;
    endcase
    have = full && (int'(blk_samples) < n);
    if (have) begin
      mag = raw[8:0];
      res.sample_value   = raw[9] ? piqsu_pkg::SAMPLE_W'(-int'(mag)) :
                                    piqsu_pkg::SAMPLE_W'(mag);
      res.channel        = rx_chan;
      res.sample_index   = blk_samples;
      res.last_in_packet = (rx_chan == piqsu_pkg::CHAN_Q_ODD) &&
                           (int'(blk_samples) + 1 == n);
      blk_samples = blk_samples + 1'b1;
    end
    prev_byte = b;
    grp_phase = (grp_phase >= piqsu_pkg::PHASE_S3) ? piqsu_pkg::PHASE_HEAD :
                                                     grp_phase + 3'd1;
    len = 2 * ((10 * n) >> 4) + 2;
    if (int'(blk_pos) + 1 >= len) begin
      blk_pos     = '0;
      blk_samples = '0;
      grp_phase   = piqsu_pkg::PHASE_HEAD;
      rx_chan     = rx_chan + 1'b1;
    end else begin
      blk_pos = blk_pos + 1'b1;
    end
  endfunction

  function automatic stim_row_t mk_row(row_kind_t kind,
                                       logic [piqsu_pkg::BYTE_W-1:0] value,
                                       logic [piqsu_pkg::CFG_W-1:0] quads_val,
                                       logic signed [piqsu_pkg::SAMPLE_W-1:0] v,
                                       logic [piqsu_pkg::CHAN_W-1:0] ch,
                                       logic [piqsu_pkg::INDEX_W-1:0] idx,
                                       logic last);
    stim_row_t r;
    r.kind      = kind;
    r.value     = value;
    r.quads_val = quads_val;
    r.want      = '{v, ch, idx, last};
    return r;
  endfunction

  // Offers one byte, with random idle cycles first, and returns on its transfer.
  task automatic offer_byte(input logic [piqsu_pkg::BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.payload_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  // Writes the quad count once every sample is out and the pipeline has settled.
  task automatic write_quads(input logic [piqsu_pkg::CFG_W-1:0] v);
    byte_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    quads = v;
  endtask

  // Sample receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.ready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      sample_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      sample_ch.ready <= 1'b0;
    end else begin
      sample_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Scoreboard: each sample transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      got_sample = '{sample_ch.sample_value, sample_ch.channel, sample_ch.sample_index,
                     sample_ch.last_in_packet};
      if (expected_samples.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected sample: value %0d ch %0d idx %0d last %0d",
                   got_sample.sample_value, got_sample.channel,
                   got_sample.sample_index, got_sample.last_in_packet);
      end else begin
        want_sample = expected_samples.pop_front();
        if (got_sample !== want_sample) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("sample mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want_sample.sample_value, want_sample.channel,
                     want_sample.sample_index, want_sample.last_in_packet,
                     got_sample.sample_value, got_sample.channel,
                     got_sample.sample_index, got_sample.last_in_packet);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    bit                           have;
    sample_t                      pred;
    logic [piqsu_pkg::BYTE_W-1:0] b;
    rst                  <= 1'b1;
    cfg_write_en         <= 1'b0;
    cfg_write_data       <= '0;
    byte_ch.valid        <= 1'b0;
    byte_ch.payload_byte <= '0;
    decoder_reset();

    // After reset each channel block is two bytes carrying one sample.
    rows.push_back(mk_row(ROW_QUIET, 8'hFF, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_TYPED, 8'hC0, '0, -10'sd511, piqsu_pkg::CHAN_I_EVEN,
                          16'd0, 1'b0));
    rows.push_back(mk_row(ROW_QUIET, 8'h7F, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_TYPED, 8'hC0, '0, 10'sd511, piqsu_pkg::CHAN_I_ODD,
                          16'd0, 1'b0));
    // Sign set with zero magnitude decodes to zero.
    rows.push_back(mk_row(ROW_QUIET, 8'h80, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_TYPED, 8'h00, '0, 10'sd0, piqsu_pkg::CHAN_Q_EVEN,
                          16'd0, 1'b0));
    rows.push_back(mk_row(ROW_QUIET, 8'h00, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_TYPED, 8'h7F, '0, 10'sd1, piqsu_pkg::CHAN_Q_ODD,
                          16'd0, 1'b1));
    rows.push_back(mk_row(ROW_QUIET, 8'h00, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_TYPED, 8'h00, '0, 10'sd0, piqsu_pkg::CHAN_I_EVEN,
                          16'd0, 1'b0));
    // Four samples per block: a full five-byte group and one padding byte.
    rows.push_back(mk_row(ROW_CFG, '0, 16'd4, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'hA5, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'h3C, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'hF0, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'h0F, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'h5A, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'h99, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'h00, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'hFF, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'h00, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'hFF, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'h00, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_CHECKED, 8'hFF, '0, '0, '0, '0, 1'b0));
    // A zero count leaves blocks of padding only.
    rows.push_back(mk_row(ROW_CFG, '0, 16'd0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_QUIET, 8'h55, '0, '0, '0, '0, 1'b0));
    rows.push_back(mk_row(ROW_QUIET, 8'hAA, '0, '0, '0, '0, 1'b0));

    // Random phases: count, idle percentage, stall percentage, items, hold-off, drain.
    plan[0] = '{16'd1, 0, 0, 250, 20, -1};
    plan[1] = '{16'd4, 71, 0, 250, -1, -1};
    plan[2] = '{16'($urandom_range(2, 12)), 0, 71, 250, -1, -1};
    plan[3] = '{16'hFFFF, 13, 13, 300, -1, -1};
    plan[4] = '{16'd0, 0, 0, 100, -1, -1};
    plan[5] = '{16'($urandom_range(5, 40)), 13, 13, 300, -1, -1};
    plan[6] = '{16'($urandom_range(1, 12)), 71, 0, 200, -1, 100};
    plan[7] = '{16'd7, 0, 71, 200, -1, -1};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) begin
        write_quads(rows[r].quads_val);
      end else begin
        offer_byte(rows[r].value);
        decode_step(rows[r].value, have, pred);
        case (rows[r].kind)
          ROW_TYPED: expected_samples.push_back(rows[r].want);
          ROW_CHECKED: if (have) expected_samples.push_back(pred);
          default: ;
        endcase
      end
    end

    // Random phases, each under its own count and idling pattern.
    foreach (plan[p]) begin
      write_quads(plan[p].quads_val);
      idle_pct  = plan[p].idle;
      stall_pct = plan[p].stall;
      for (int i = 0; i < plan[p].count; i++) begin
        if (i == plan[p].hold_at) hold_asked++;
        if (i == plan[p].drain_at) begin
          byte_ch.valid <= 1'b0;
          while (expected_samples.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        case ($urandom_range(9))
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = 8'h80;
          default: b = 8'($urandom_range(255));
        endcase
        offer_byte(b);
        decode_step(b, have, pred);
        if (have) expected_samples.push_back(pred);
      end
    end

    // Drain and finish.
    byte_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
